// ----- hw/rtl/wsfp_pkg.sv -----
package wsfp_pkg;

   localparam logic [6:0] LEN16_CODE  = 7'd126;
   localparam logic [6:0] LEN64_CODE  = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [4:0] {
      PH_BYTE0   = 5'b00001,
      PH_BYTE1   = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_KEY     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_item_type;

endpackage

// ----- hw/rtl/wsfp_in_reg.sv -----
module wsfp_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   take,
   output wsfp_pkg::byte_item_type item
);
   import wsfp_pkg::*;

   logic       full_ff;
   logic       full_in;
   logic [7:0] byte_ff;
   logic       load;

   assign load      = !full_ff || take;
   assign req_stall = full_ff && !take;
   assign full_in   = load ? req_valid : full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item.valid = full_ff;
   assign item.data  = byte_ff;

endmodule

// ----- hw/rtl/wsfp_parser.sv -----
module wsfp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  wsfp_pkg::byte_item_type item,
   output logic                    take,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_result_kind,
   output logic [3:0]              rsp_opcode,
   output logic                    rsp_final_fragment,
   output logic                    rsp_masked,
   output logic [63:0]             rsp_payload_length,
   output logic [7:0]              rsp_data_byte,
   output logic                    rsp_last
);
   import wsfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] rem_ff, rem_in;
   logic [1:0]  kidx_ff, kidx_in;
   logic [3:0]  op_ff, op_in;
   logic        fin_ff, fin_in;
   logic        mask_ff, mask_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   logic [3:0]  out_op_ff;
   logic        out_fin_ff;
   logic        out_mask_ff;
   logic [63:0] out_len_ff;
   logic [7:0]  out_data_ff;
   logic        out_last_ff;

   logic        emit;
   logic        hdr_done;
   logic        o_kind;
   logic [7:0]  o_data;
   logic        o_last;
   logic [7:0]  key_byte;
   logic        out_free;
   logic [7:0]  b;

   assign b = item.data;

   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      rem_in   = rem_ff;
      kidx_in  = kidx_ff;
      op_in    = op_ff;
      fin_in   = fin_ff;
      mask_in  = mask_ff;
      emit     = 1'b0;
      hdr_done = 1'b0;
      o_kind   = KIND_HEADER;
      o_data   = 8'd0;
      o_last   = 1'b0;
      case (phase_ff)
         PH_BYTE0: begin
            op_in    = b[3:0];
            fin_in   = b[7];
            phase_in = PH_BYTE1;
         end
         PH_BYTE1: begin
            mask_in = b[7];
            key_in  = 32'd0;
            len_in  = 64'd0;
            if (b[6:0] == LEN16_CODE) begin
               cnt_in   = EXT16_BYTES;
               phase_in = PH_EXTLEN;
            end else if (b[6:0] == LEN64_CODE) begin
               cnt_in   = EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               len_in = {57'd0, b[6:0]};
               if (b[7]) begin
                  cnt_in   = KEY_BYTES;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_EXTLEN: begin
            len_in = {len_ff[55:0], b};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_in == 4'd0) begin
               if (mask_ff) begin
                  cnt_in   = KEY_BYTES;
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], b};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_in == 4'd0) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            emit    = 1'b1;
            o_kind  = KIND_PAYLOAD;
            o_data  = b ^ key_byte;
            o_last  = (rem_ff == 64'd1);
            rem_in  = rem_ff - 64'd1;
            kidx_in = kidx_ff + 2'd1;
            if (o_last) begin
               phase_in = PH_BYTE0;
            end
         end
         default: begin
            phase_in = PH_BYTE0;
         end
      endcase
      if (hdr_done) begin
         emit     = 1'b1;
         o_kind   = KIND_HEADER;
         o_data   = 8'd0;
         o_last   = (len_in == 64'd0);
         phase_in = o_last ? PH_BYTE0 : PH_PAYLOAD;
         rem_in   = len_in;
         kidx_in  = 2'd0;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign take     = item.valid && (!emit || out_free);

   always_comb begin
      if (take && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BYTE0;
         cnt_ff       <= 4'd0;
         len_ff       <= 64'd0;
         key_ff       <= 32'd0;
         rem_ff       <= 64'd0;
         kidx_ff      <= 2'd0;
         op_ff        <= 4'd0;
         fin_ff       <= 1'b0;
         mask_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            len_ff   <= len_in;
            key_ff   <= key_in;
            rem_ff   <= rem_in;
            kidx_ff  <= kidx_in;
            op_ff    <= op_in;
            fin_ff   <= fin_in;
            mask_ff  <= mask_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_kind_ff <= o_kind;
         out_op_ff   <= op_in;
         out_fin_ff  <= fin_in;
         out_mask_ff <= mask_in;
         out_len_ff  <= len_in;
         out_data_ff <= o_data;
         out_last_ff <= o_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_opcode         = out_op_ff;
   assign rsp_final_fragment = out_fin_ff;
   assign rsp_masked         = out_mask_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_last           = out_last_ff;

   header_has_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_HEADER) |-> out_data_ff == 8'd0)
      else $error("header result carries data");

   header_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXTLEN || phase_ff == PH_KEY) |-> cnt_ff != 4'd0)
      else $error("header byte count ran out inside header");

   last_byte_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == PH_PAYLOAD && rem_ff == 64'd1) |=> phase_ff == PH_BYTE0)
      else $error("frame did not end after last payload byte");

   payload_not_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> rem_ff != 64'd0)
      else $error("payload phase with no bytes left");

endmodule

// ----- hw/rtl/websocket_frame_parser_unit.sv -----
// websocket frame parser
// req channel: one raw byte of the frame stream per transfer (req_in_byte).
// rsp channel: at most one result per input byte; a header result
// (rsp_result_kind 0) once the header and any masking key are complete,
// then one unmasked payload byte (rsp_result_kind 1) per payload byte.
// rsp_last marks the final payload byte, or the header of an empty frame.
// header bytes themselves give no result.
// a byte accepted into the input register moves into the result register
// when the parser takes it, and its result can transfer from there;
// one byte per cycle while no stalled result holds the parser back, since
// the parser updates its state as it takes each byte.
// a new byte is taken while a finished result still waits in the
// result register; only a byte that would produce a result waits for it.
// reset clears the parser to expect the first header byte of a new
// frame and empties both registers.
// while rsp_stall is high the result holds; once a byte that would produce
// a result sits in the input register behind it, req_stall rises.
module websocket_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_final_fragment,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);
   import wsfp_pkg::*;

   byte_item_type item;
   logic          take;

   wsfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .take        (take),
      .item        (item)
   );

   wsfp_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .item               (item),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_opcode         (rsp_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last)
   );

endmodule
